>>> hw/rtl/pbm_p4_to_gray_decoder_macros.svh
// ----------------------------------------------------------------------------
// PBM decoder assertion macros
// Shared concurrent assertion forms, synchronous to a clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef PBM_P4_TO_GRAY_DECODER_MACROS_SVH
`define PBM_P4_TO_GRAY_DECODER_MACROS_SVH

// same-cycle implication
`define PBM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pbm decoder: assertion failed");

// next-cycle implication
`define PBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pbm decoder: assertion failed");

`endif

>>> hw/rtl/pbm_pkg.sv
// ----------------------------------------------------------------------------
// PBM decoder package
// Character codes, result kinds, parser phases and the queue entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pbm_pkg;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [7:0] PIX_BLACK = 8'h00;
    localparam logic [7:0] PIX_WHITE = 8'hFF;

    localparam int unsigned OUT_DIM_W = 14;

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    typedef enum logic [3:0] {
        PH_P,
        PH_4,
        PH_NL,
        PH_FIRST,
        PH_COMMENT,
        PH_WIDTH,
        PH_HEIGHT,
        PH_DATA,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        CMD_ERROR,
        CMD_HEADER,
        CMD_DATA
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
    } t_qent;

endpackage

`default_nettype wire

>>> hw/rtl/pbm_in_if.sv
// ----------------------------------------------------------------------------
// PBM byte channel
// Valid/ready channel carrying one raw file byte per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pbm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pbm_out_if.sv
// ----------------------------------------------------------------------------
// PBM result channel
// Valid/ready channel carrying one pixel, header or error result per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pbm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  pixel;
    logic        row_end;
    logic        image_end;
    logic [13:0] image_width;
    logic [13:0] image_height;
    logic        last;

    modport source (output valid, output kind, output pixel, output row_end,
                    output image_end, output image_width, output image_height,
                    output last, input ready);
    modport sink   (input valid, input kind, input pixel, input row_end,
                    input image_end, input image_width, input image_height,
                    input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pbm_p4_to_gray_decoder.sv
// ----------------------------------------------------------------------------
// PBM P4 to gray decoder
// Parses a binary PBM stream byte by byte and emits 8-bit gray pixels.
//
// i_in carries one file byte per request; o_out carries pixel, header and
// error results, with last set on the final result of each input byte.
// A header parser accepts bytes whenever its two-entry command queue has
// room; the pixel expander drains the queue into a registered output slot.
// A header or error result passes through the queue and the output slot;
// each pixel of a data byte passes through the queue, the expander's byte
// register and the output slot. The expander pops a data byte, emits its
// pixels one by one and pops the next command only after the last pixel.
// When o_out stalls the output slot holds, the expander waits, the queue
// fills and i_in.ready drops. Reset clears the parser to expect the magic
// and empties the queue and output slot.
// A mismatch in the magic gives one error result and later bytes are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbm_p4_to_gray_decoder #(
    parameter int unsigned MAX_DIM = 16383
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    pbm_in_if.sink       i_in,
    pbm_out_if.source    o_out
);
    import pbm_pkg::*;

    localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

    logic             q_full;
    logic             q_valid;
    logic             q_push;
    logic             q_pop;
    t_qent            q_push_ent;
    t_qent            q_ent;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;

    pbm_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_push_ent (q_push_ent),
        .o_width    (width),
        .o_height   (height)
    );

    pbm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_ent (q_push_ent),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_ent      (q_ent),
        .i_pop      (q_pop)
    );

    pbm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_ent   (q_ent),
        .o_q_pop   (q_pop),
        .i_width   (width),
        .i_height  (height),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

>>> hw/rtl/pbm_front.sv
// ----------------------------------------------------------------------------
// PBM header parser
// Checks the magic, skips the comment, parses width and height, and queues
// error, header and data-byte commands for the pixel expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbm_front #(
    parameter int unsigned MAX_DIM = 16383
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    pbm_in_if.sink                        i_in,
    input  wire                           i_q_full,
    output logic                          o_push,
    output pbm_pkg::t_qent                o_push_ent,
    output logic [$clog2(MAX_DIM+1)-1:0]  o_width,
    output logic [$clog2(MAX_DIM+1)-1:0]  o_height
);
    import pbm_pkg::*;

    localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
    localparam int unsigned ACC_W = DIM_W + 4;

    t_phase             r_phase, n_phase;
    logic [DIM_W-1:0]   r_width, n_width;
    logic [DIM_W-1:0]   r_height, n_height;
    logic               r_stopped, n_stopped;
    logic               accept;
    logic               is_digit;
    logic [DIM_W-1:0]   width_acc;
    logic [DIM_W-1:0]   height_acc;

    function automatic logic [DIM_W-1:0] f_mac10(input logic [DIM_W-1:0] acc,
                                                 input logic [3:0] digit);
        logic [ACC_W-1:0] v;
        v = (ACC_W'(acc) << 3) + (ACC_W'(acc) << 1) + ACC_W'(digit);
        if (v > ACC_W'(MAX_DIM)) begin
            v = ACC_W'(MAX_DIM);
        end
        return v[DIM_W-1:0];
    endfunction

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign is_digit   = (i_in.data_byte >= CH_0) && (i_in.data_byte <= CH_9);
    assign width_acc  = (r_stopped || !is_digit) ? r_width
                                                 : f_mac10(r_width, i_in.data_byte[3:0]);
    assign height_acc = (r_stopped || !is_digit) ? r_height
                                                 : f_mac10(r_height, i_in.data_byte[3:0]);
    assign o_width    = r_width;
    assign o_height   = r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_P;
            r_width   <= '0;
            r_height  <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_width   <= n_width;
            r_height  <= n_height;
            r_stopped <= n_stopped;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_width         = r_width;
        n_height        = r_height;
        n_stopped       = r_stopped;
        o_push          = 1'b0;
        o_push_ent.cmd  = CMD_DATA;
        o_push_ent.data = i_in.data_byte;
        if (accept) begin
            unique case (r_phase)
                PH_P, PH_4, PH_NL: begin
                    if ((r_phase == PH_P  && i_in.data_byte != CH_P) ||
                        (r_phase == PH_4  && i_in.data_byte != CH_4) ||
                        (r_phase == PH_NL && i_in.data_byte != CH_NL)) begin
                        n_phase        = PH_ERROR;
                        o_push         = 1'b1;
                        o_push_ent.cmd = CMD_ERROR;
                    end else if (r_phase == PH_P) begin
                        n_phase = PH_4;
                    end else if (r_phase == PH_4) begin
                        n_phase = PH_NL;
                    end else begin
                        n_phase = PH_FIRST;
                    end
                end
                PH_FIRST: begin
                    if (i_in.data_byte == CH_HASH) begin
                        n_phase = PH_COMMENT;
                    end else begin
                        n_width   = width_acc;
                        n_stopped = r_stopped || !is_digit;
                        n_phase   = PH_WIDTH;
                    end
                end
                PH_COMMENT: begin
                    if (i_in.data_byte == CH_NL) begin
                        n_phase = PH_WIDTH;
                    end
                end
                PH_WIDTH: begin
                    if (i_in.data_byte == CH_SPACE) begin
                        n_stopped = 1'b0;
                        n_phase   = PH_HEIGHT;
                    end else begin
                        n_width   = width_acc;
                        n_stopped = r_stopped || !is_digit;
                    end
                end
                PH_HEIGHT: begin
                    if (i_in.data_byte == CH_NL) begin
                        n_phase        = PH_DATA;
                        o_push         = 1'b1;
                        o_push_ent.cmd = CMD_HEADER;
                    end else begin
                        n_height  = height_acc;
                        n_stopped = r_stopped || !is_digit;
                    end
                end
                PH_DATA: begin
                    o_push = 1'b1;
                end
                PH_ERROR: begin
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pbm_queue.sv
// ----------------------------------------------------------------------------
// PBM command queue
// Two-entry queue between the header parser and the pixel expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbm_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  pbm_pkg::t_qent  i_push_ent,
    output logic            o_full,
    output logic            o_valid,
    output pbm_pkg::t_qent  o_ent,
    input  wire             i_pop
);
    import pbm_pkg::*;

    `include "pbm_p4_to_gray_decoder_macros.svh"

    t_qent      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_ent   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    `PBM_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `PBM_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid)
    `PBM_ASSERT_IMPL(a_ptr_count, i_clk, i_rst_n, (r_count == 2'd0 || r_count == 2'd2), r_wptr == r_rptr)

endmodule

`default_nettype wire

>>> hw/rtl/pbm_back.sv
// ----------------------------------------------------------------------------
// PBM pixel expander
// Pops queued commands, emits header and error results, and expands each
// data byte MSB first into gray pixels, tracking column and row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pbm_back #(
    parameter int unsigned MAX_DIM = 16383
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_q_valid,
    input  pbm_pkg::t_qent                i_q_ent,
    output logic                          o_q_pop,
    input  wire [$clog2(MAX_DIM+1)-1:0]   i_width,
    input  wire [$clog2(MAX_DIM+1)-1:0]   i_height,
    pbm_out_if.source                     o_out
);
    import pbm_pkg::*;

    `include "pbm_p4_to_gray_decoder_macros.svh"

    localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
    localparam int unsigned CNT_W = DIM_W + 4;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [7:0]            r_byte, n_byte;
    logic [2:0]            r_bit, n_bit;
    logic [CNT_W-1:0]      r_col, n_col;
    logic [DIM_W-1:0]      r_row, n_row;

    logic                  r_o_valid;
    logic [1:0]            r_o_kind, n_o_kind;
    logic [7:0]            r_o_pixel, n_o_pixel;
    logic                  r_o_row_end, n_o_row_end;
    logic                  r_o_image_end, n_o_image_end;
    logic [OUT_DIM_W-1:0]  r_o_width, n_o_width;
    logic [OUT_DIM_W-1:0]  r_o_height, n_o_height;
    logic                  r_o_last, n_o_last;

    logic                  out_free;
    logic                  load;
    logic [CNT_W-1:0]      cw;
    logic [CNT_W-1:0]      col_now;
    logic [CNT_W-1:0]      col_inc;
    logic [CNT_W-1:0]      col8;
    logic [DIM_W:0]        row_inc;
    logic                  pix_last;
    logic                  row_end;

    assign out_free = !r_o_valid || o_out.ready;
    assign cw       = CNT_W'(i_width);
    assign col_now  = r_col + CNT_W'(r_bit);
    assign col_inc  = col_now + CNT_W'(1);
    assign col8     = r_col + CNT_W'(8);
    assign row_inc  = {1'b0, r_row} + (DIM_W+1)'(1);
    assign row_end  = (col_inc == cw);
    assign pix_last = (r_bit == 3'd7) || (col_inc >= cw);

    always_comb begin
        n_busy        = r_busy;
        n_done        = r_done;
        n_byte        = r_byte;
        n_bit         = r_bit;
        n_col         = r_col;
        n_row         = r_row;
        o_q_pop       = 1'b0;
        load          = 1'b0;
        n_o_kind      = KIND_PIXEL;
        n_o_pixel     = PIX_BLACK;
        n_o_row_end   = 1'b0;
        n_o_image_end = 1'b0;
        n_o_width     = '0;
        n_o_height    = '0;
        n_o_last      = 1'b0;
        if (out_free) begin
            if (r_busy) begin
                load          = 1'b1;
                n_o_pixel     = r_byte[~r_bit] ? PIX_BLACK : PIX_WHITE;
                n_o_row_end   = row_end;
                n_o_image_end = row_end && (row_inc == {1'b0, i_height});
                n_o_last      = pix_last;
                if (pix_last) begin
                    n_busy = 1'b0;
                    if (col8 >= cw) begin
                        n_col = '0;
                        n_row = row_inc[DIM_W-1:0];
                        if (row_inc >= {1'b0, i_height}) begin
                            n_done = 1'b1;
                        end
                    end else begin
                        n_col = col8;
                    end
                end else begin
                    n_bit = r_bit + 3'd1;
                end
            end else if (i_q_valid) begin
                o_q_pop = 1'b1;
                unique case (i_q_ent.cmd)
                    CMD_ERROR: begin
                        load     = 1'b1;
                        n_o_kind = KIND_ERROR;
                        n_o_last = 1'b1;
                    end
                    CMD_HEADER: begin
                        load       = 1'b1;
                        n_o_kind   = KIND_HEADER;
                        n_o_width  = OUT_DIM_W'(i_width);
                        n_o_height = OUT_DIM_W'(i_height);
                        n_o_last   = 1'b1;
                        n_col      = '0;
                        n_row      = '0;
                        n_done     = (i_width == '0) || (i_height == '0);
                    end
                    CMD_DATA: begin
                        if (!r_done) begin
                            n_busy = 1'b1;
                            n_byte = i_q_ent.data;
                            n_bit  = 3'd0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_bit     <= 3'd0;
            r_col     <= '0;
            r_row     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_bit  <= n_bit;
            r_col  <= n_col;
            r_row  <= n_row;
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (load) begin
            r_o_kind      <= n_o_kind;
            r_o_pixel     <= n_o_pixel;
            r_o_row_end   <= n_o_row_end;
            r_o_image_end <= n_o_image_end;
            r_o_width     <= n_o_width;
            r_o_height    <= n_o_height;
            r_o_last      <= n_o_last;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.kind         = r_o_kind;
    assign o_out.pixel        = r_o_pixel;
    assign o_out.row_end      = r_o_row_end;
    assign o_out.image_end    = r_o_image_end;
    assign o_out.image_width  = r_o_width;
    assign o_out.image_height = r_o_height;
    assign o_out.last         = r_o_last;

    `PBM_ASSERT_IMPL(a_busy_not_done, i_clk, i_rst_n, r_busy, !r_done)
    `PBM_ASSERT_IMPL(a_col_in_row, i_clk, i_rst_n, r_busy, col_now < cw)
    `PBM_ASSERT_NEXT(a_header_result, i_clk, i_rst_n, o_q_pop && i_q_ent.cmd == CMD_HEADER, r_o_valid && r_o_kind == KIND_HEADER && r_o_last)

endmodule

`default_nettype wire
